// ===== hw/rtl/pixel_stack_merge_unit_macros.svh =====
// Assertion macros shared by the pixel stack merge RTL.
`ifndef PIXEL_STACK_MERGE_UNIT_MACROS_SVH
`define PIXEL_STACK_MERGE_UNIT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define PSM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PSM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/psm_pkg.sv =====
// Shared widths, register indexes and defaults for the pixel stack merge unit.
package psm_pkg;

  // Field and state widths
  localparam int COLOR_W   = 16;
  localparam int SUM_W     = 24;
  localparam int CNT_W     = 9;
  localparam int COUNT_CAP = 511;

  // Divider sequencing: one quotient bit per step
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MERGE_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_IN_USE = 1'b1;

  // Parameter defaults
  localparam int DEF_COLOR_BITS = 16;
  localparam int DEF_MAX_FRAMES = 256;

endpackage

// ===== hw/rtl/psm_if.sv =====
// Stream interfaces for the sample input and the merged result output.
interface psm_in_if import psm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] sample_value;
  logic               sample_valid;
  logic               last_of_pixel;

  modport source (output valid, sample_value, sample_valid, last_of_pixel, input ready);
  modport sink   (input valid, sample_value, sample_valid, last_of_pixel, output ready);
endinterface

interface psm_out_if import psm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] merged_value;
  logic               covered;

  modport source (output valid, merged_value, covered, input ready);
  modport sink   (input valid, merged_value, covered, output ready);
endinterface

// ===== hw/rtl/pixel_stack_merge_unit.sv =====
// Pixel stack merge unit: masked mean or minimum over one pixel's frame stack.
//
// Samples enter on the samples channel (valid/ready); one transfer carries one
// frame's value of the current pixel, its coverage flag and a last flag.
// A sample without the last flag leaves the unit idle, so it stays ready
// for the next sample.
// On the last sample one result leaves on the results channel. In darkest
// mode, or with no covered sample, the result passes from the finish state
// into the output register once that is free. In average mode the mean comes
// from a restoring divider that resolves one quotient bit per cycle, 24 steps,
// and then passes through the finish state into the output register; the
// unit takes no sample meanwhile.
// The output register holds a result until the receiver takes it; samples of
// the next pixel are still taken then, and only the next result waits for it.
// Registers merge_mode and alpha_in_use are written on the cfg port; the user
// must write them only while the unit is idle, as the unit does not enforce it.
// Reset (synchronous, active high) selects average mode with alpha in use, clears
// the sum and count, sets the minimum to full scale and drops any pending result.
`include "pixel_stack_merge_unit_macros.svh"

module pixel_stack_merge_unit import psm_pkg::*; #(
  parameter int COLOR_BITS = DEF_COLOR_BITS,
  parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  psm_in_if.sink                samples,
  psm_out_if.source             results
);

  localparam int COUNT_LIMIT = (MAX_FRAMES < COUNT_CAP) ? MAX_FRAMES : COUNT_CAP;
  localparam logic [CNT_W-1:0] COUNT_LIMIT_V = CNT_W'(COUNT_LIMIT);
  localparam logic [COLOR_W-1:0] FULL_SCALE =
    (COLOR_BITS >= COLOR_W) ? '1 : COLOR_W'((64'd1 << COLOR_BITS) - 64'd1);
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t             state;
  logic               merge_mode;
  logic               alpha_in_use;
  logic [SUM_W-1:0]   running_sum;
  logic [CNT_W-1:0]   valid_count;
  logic [COLOR_W-1:0] running_min;
  logic               out_valid;
  logic [COLOR_W-1:0] out_value;
  logic               out_covered;

  logic               in_xfer;
  logic               out_free;
  logic               load_out;
  logic [SUM_W:0]     sum_ext;
  logic [SUM_W-1:0]   sum_next;
  logic [CNT_W-1:0]   count_next;
  logic [COLOR_W-1:0] min_next;
  logic               div_start;
  logic               div_done;
  logic [SUM_W-1:0]   div_quotient;
  logic               no_valid;

  assign samples.ready = (state == ST_IDLE);
  assign in_xfer       = samples.valid && samples.ready;
  assign out_free      = !out_valid || results.ready;
  assign load_out      = (state == ST_FINISH) && out_free;
  assign no_valid      = (valid_count == '0);

  // Accumulator update for the incoming sample
  always_comb begin
    sum_ext    = {1'b0, running_sum} + {{(SUM_W + 1 - COLOR_W){1'b0}}, samples.sample_value};
    sum_next   = running_sum;
    count_next = valid_count;
    min_next   = running_min;
    if (samples.sample_valid) begin
      if (valid_count < COUNT_LIMIT_V) begin
        sum_next   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
        count_next = valid_count + 1'b1;
      end
      if (samples.sample_value < running_min) begin
        min_next = samples.sample_value;
      end
    end
  end

  // Divide starts on the last sample of an average-mode pixel with coverage
  assign div_start = in_xfer && samples.last_of_pixel && !merge_mode && (count_next != '0);

  psm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (count_next),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Sequencer, accumulators, config registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      merge_mode   <= 1'b0;
      alpha_in_use <= 1'b1;
      running_sum  <= '0;
      valid_count  <= '0;
      running_min  <= FULL_SCALE;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MERGE_MODE:   merge_mode   <= cfg_data[0];
          REG_ALPHA_IN_USE: alpha_in_use <= cfg_data[0];
        endcase
      end

      // Output valid: a new result wins over the transfer of the old one
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            running_sum <= sum_next;
            valid_count <= count_next;
            running_min <= min_next;
            if (samples.last_of_pixel) begin
              state <= div_start ? ST_DIV : ST_FINISH;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_covered <= merge_mode || !no_valid || !alpha_in_use;
            if (merge_mode) begin
              out_value <= running_min;
            end else if (no_valid) begin
              out_value <= '0;
            end else begin
              out_value <= div_quotient[COLOR_W-1:0];
            end
            running_sum <= '0;
            valid_count <= '0;
            running_min <= FULL_SCALE;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign results.valid        = out_valid;
  assign results.merged_value = out_value;
  assign results.covered      = out_covered;

  // Checks
  `PSM_ASSERT(a_done_in_div, clk, rst, div_done |-> state == ST_DIV, "divider done outside divide state")
  `PSM_ASSERT(a_count_limit, clk, rst, valid_count <= COUNT_LIMIT_V, "valid count above limit")
  `PSM_ASSERT(a_empty_sum, clk, rst, no_valid |-> running_sum == '0, "sum nonzero with no valid sample")
  `PSM_ASSERT(a_clear_after_load, clk, rst, (state == ST_FINISH && out_free) |=> (no_valid && running_min == FULL_SCALE), "accumulators not cleared after result")
  `PSM_ASSERT(a_uncovered_zero, clk, rst, (results.valid && !results.covered) |-> results.merged_value == '0, "uncovered result with nonzero value")

endmodule

// ===== hw/rtl/psm_div.sv =====
// Iterative restoring divider: one quotient bit per cycle.
module psm_div import psm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  logic             busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] dvsr;
  logic [SUM_W-1:0] quo;

  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             fits;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem, quo[SUM_W-1]};
    diff  = trial - {1'b0, dvsr};
    fits  = trial >= {1'b0, dvsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        quo  <= dividend;
        dvsr <= divisor;
      end else if (busy) begin
        rem  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo  <= {quo[SUM_W-2:0], fits};
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== dv/pixel_stack_merge_unit_tb.sv =====
// Self-checking testbench for the pixel stack merge unit (masked mean or darkest per pixel).
module pixel_stack_merge_unit_tb;
  import psm_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int SETTLE_CYCLES  = 40;   // divider is 24 steps plus output staging
  localparam int HOLDOFF_CYCLES = 300;
  localparam int LONG_STACK     = 280;  // pushes the valid count past its cap
  localparam int PHASE_ITEMS    = 85;

  typedef enum logic {MODE_AVERAGE = 1'b0, MODE_DARKEST = 1'b1} merge_mode_t;

  typedef struct packed {
    logic [COLOR_W-1:0] merged_value;
    logic               covered;
  } merge_result_t;

  // Tracks the pixel stack in flight and the merged results still owed by the unit
  class merge_scoreboard;
    merge_mode_t        mode;
    logic               alpha_on;
    logic [SUM_W-1:0]   acc_sum;
    logic [CNT_W-1:0]   acc_count;
    logic [COLOR_W-1:0] acc_min;
    merge_result_t      expected_merges[$];
    int                 failures;
    int                 samples_seen;
    int                 merges_checked;

    function new();
      mode           = MODE_AVERAGE;
      alpha_on       = 1'b1;
      failures       = 0;
      samples_seen   = 0;
      merges_checked = 0;
      clear_stack();
    endfunction

    function void clear_stack();
      acc_sum   = '0;
      acc_count = '0;
      acc_min   = (DEF_COLOR_BITS >= COLOR_W) ? {COLOR_W{1'b1}} :
                  COLOR_W'((1 << DEF_COLOR_BITS) - 1);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MERGE_MODE:   mode = merge_mode_t'(data[0]);
        REG_ALPHA_IN_USE: alpha_on = data[0];
        default: ;
      endcase
    endfunction

    // Accumulate one accepted sample; a last sample produces the expected merge
    function void note_sample(logic [COLOR_W-1:0] value, logic valid, logic last);
      logic [SUM_W:0] grown;
      merge_result_t  res;
      int             count_cap;
      count_cap = (DEF_MAX_FRAMES < COUNT_CAP) ? DEF_MAX_FRAMES : COUNT_CAP;
      samples_seen++;
      if (valid) begin
        // sum and count stop at the cap; the minimum keeps tracking
        if (int'(acc_count) < count_cap) begin
          grown     = acc_sum + value;
          acc_sum   = (grown > {SUM_W{1'b1}}) ? {SUM_W{1'b1}} : grown[SUM_W-1:0];
          acc_count = acc_count + 1'b1;
        end
        if (value < acc_min) acc_min = value;
      end
      if (!last) return;
      res.covered = 1'b1;
      if (mode == MODE_DARKEST) begin
        res.merged_value = acc_min;
      end else if (acc_count != 0) begin
        res.merged_value = COLOR_W'(acc_sum / acc_count);
      end else begin
        res.merged_value = '0;
        if (alpha_on) res.covered = 1'b0;
      end
      expected_merges = {expected_merges, res};
      clear_stack();
    endfunction

    function void check_result(logic [COLOR_W-1:0] value, logic covered);
      merge_result_t want;
      if (expected_merges.size() == 0) begin
        $error("unexpected merged result: merged_value %0d covered %0d", value, covered);
        failures++;
        return;
      end
      want = expected_merges.pop_front();
      merges_checked++;
      if (value !== want.merged_value) begin
        $error("merged_value mismatch: expected %0d, actual %0d", want.merged_value, value);
        failures++;
      end
      if (covered !== want.covered) begin
        $error("covered mismatch: expected %0d, actual %0d", want.covered, covered);
        failures++;
      end
    endfunction

    function int pending();
      return expected_merges.size();
    endfunction

    function void flag_leftovers();
      if (expected_merges.size() != 0) begin
        $error("%0d merged results never arrived", expected_merges.size());
        failures += expected_merges.size();
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  psm_in_if  samples_ch();
  psm_out_if results_ch();

  merge_scoreboard scoreboard;

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int holdoff_req   = 0;
  int holdoff_seen  = 0;
  int holdoff_left  = 0;
  int cycle_count   = 0;
  int settings_used = 0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  pixel_stack_merge_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples_ch),
    .results   (results_ch)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (holdoff_req != holdoff_seen) begin
      holdoff_seen = holdoff_req;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left = holdoff_left - 1;
      results_ch.ready <= 1'b0;
    end else begin
      results_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && results_ch.valid && results_ch.ready)
      scoreboard.check_result(results_ch.merged_value, results_ch.covered);
  end

  function automatic logic [COLOR_W-1:0] pick_value();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  // Offer one sample and hold it until the transfer
  task automatic send_sample(logic [COLOR_W-1:0] value, logic valid, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      samples_ch.valid <= 1'b0;
      @(posedge clk);
    end
    samples_ch.valid         <= 1'b1;
    samples_ch.sample_value  <= value;
    samples_ch.sample_valid  <= valid;
    samples_ch.last_of_pixel <= last;
    do @(posedge clk); while (!samples_ch.ready);
    scoreboard.note_sample(value, valid, last);
  endtask

  // One pixel stack: mostly short, sometimes fully covered or fully uncovered
  task automatic send_pixel(output int sent);
    int   kind;
    logic valid;
    kind = $urandom_range(9);
    sent = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
    for (int k = 0; k < sent; k++) begin
      valid = (kind == 0) ? 1'b0 : (kind == 1) ? 1'b1 : ($urandom_range(99) < 70);
      send_sample(pick_value(), valid, k == sent - 1);
    end
  endtask

  // Stop offering, wait for all owed results, then let the divider settle
  task automatic drain();
    samples_ch.valid <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(merge_mode_t mode, logic alpha);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MERGE_MODE;
    cfg_data  <= mode;
    @(posedge clk);
    scoreboard.write_reg(REG_MERGE_MODE, mode);
    cfg_index <= REG_ALPHA_IN_USE;
    cfg_data  <= alpha;
    @(posedge clk);
    scoreboard.write_reg(REG_ALPHA_IN_USE, alpha);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(int src_pct, int sink_pct, merge_mode_t mode, logic alpha,
                           bit long_stack, bit hold_off);
    int sent;
    int total;
    drain();
    set_registers(mode, alpha);
    src_idle_pct = src_pct;
    sink_idle_pct <= sink_pct;
    if (hold_off) holdoff_req <= holdoff_req + 1;
    // over-long stack: valid samples past the cap must not reach the mean
    if (long_stack) begin
      for (int k = 0; k < LONG_STACK; k++)
        send_sample(pick_value(), (k % 40) != 3, k == LONG_STACK - 1);
    end
    total = 0;
    while (total < PHASE_ITEMS) begin
      send_pixel(sent);
      total += sent;
    end
  endtask

  initial begin
    scoreboard = new();
    samples_ch.valid         <= 1'b0;
    samples_ch.sample_value  <= '0;
    samples_ch.sample_valid  <= 1'b0;
    samples_ch.last_of_pixel <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_MERGE_MODE;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, average mode with alpha in use
    send_sample(16'hFFFF, 1'b1, 1'b1);
    send_sample(16'h0000, 1'b1, 1'b1);
    send_sample(16'h1234, 1'b0, 1'b0);        // no covered sample -> uncovered
    send_sample(16'hFFFF, 1'b0, 1'b1);
    send_sample(16'h0001, 1'b1, 1'b0);        // truncated mean 4/3
    send_sample(16'hFFFF, 1'b0, 1'b0);
    send_sample(16'h0001, 1'b1, 1'b0);
    send_sample(16'h0002, 1'b1, 1'b1);
    send_sample(16'd100, 1'b1, 1'b0);         // last sample itself uncovered
    send_sample(16'd7, 1'b0, 1'b1);

    // Directed: darkest mode, including a stack with nothing covered
    drain();
    set_registers(MODE_DARKEST, 1'b1);
    send_sample(16'h8000, 1'b1, 1'b0);
    send_sample(16'h0001, 1'b0, 1'b0);
    send_sample(16'h7FFF, 1'b1, 1'b1);
    send_sample(16'h0000, 1'b0, 1'b1);

    // Directed: no covered sample with alpha off
    drain();
    set_registers(MODE_AVERAGE, 1'b0);
    send_sample(16'h5555, 1'b0, 1'b1);

    // Directed: mode switched in the middle of a stack, both directions
    send_sample(16'd10, 1'b1, 1'b0);
    send_sample(16'd20, 1'b1, 1'b0);
    drain();
    set_registers(MODE_DARKEST, 1'b0);
    send_sample(16'd30, 1'b1, 1'b1);
    send_sample(16'd5, 1'b1, 1'b0);
    send_sample(16'd9, 1'b1, 1'b0);
    drain();
    set_registers(MODE_AVERAGE, 1'b1);
    send_sample(16'hAAAA, 1'b0, 1'b1);

    // Random phases: idle mix swaps, then full rate with a receiver hold-off
    run_phase(37, 61, MODE_AVERAGE, 1'b1, 1'b1, 1'b0);
    run_phase(61, 37, MODE_DARKEST, 1'b0, 1'b0, 1'b0);
    run_phase(0, 0, MODE_AVERAGE, 1'b0, 1'b0, 1'b1);
    run_phase(0, 0, MODE_DARKEST, 1'b1, 1'b0, 1'b0);

    drain();
    scoreboard.flag_leftovers();
    $display("Run covered %0d sample transfers and %0d merged results over %0d settings,",
             scoreboard.samples_seen, scoreboard.merges_checked, settings_used + 1);
    $display("including a stack past the count cap, mid-stack mode changes and a long output stall.");
    if (scoreboard.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
